### hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define RYC_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent checked in the clock after the antecedent
`define RYC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/ryc_pkg.sv
`default_nettype none

package ryc_pkg;

	// one 24-bit pixel, packed red<<16 | green<<8 | blue
	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} ryc_pix_t;

	typedef struct packed {
		logic [7:0] first_red;
		logic [7:0] first_green;
		logic [7:0] first_blue;
		logic [7:0] second_red;
		logic [7:0] second_green;
		logic [7:0] second_blue;
	} ryc_in_t;

	typedef struct packed {
		logic [7:0] first_luma;
		logic [7:0] blue_chroma;
		logic [7:0] second_luma;
		logic [7:0] red_chroma;
	} ryc_out_t;

	// per-pixel results of one lane
	typedef struct packed {
		logic [7:0] luma;
		logic [7:0] cb;
		logic [7:0] cr;
	} ryc_lane_t;

	// stage advance enables handed to the lanes
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} ryc_adv_t;

	// configuration register indexes
	localparam int REG_IDX_W = 2;
	localparam int CFG_W     = 24;
	localparam logic [REG_IDX_W-1:0] REG_KEY_ENABLE    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_KEY_COLOUR    = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_REPLACE_COLOUR = 2'd2;

	localparam logic [CFG_W-1:0] KEY_COLOUR_RST     = 24'hFF00FF;
	localparam logic [CFG_W-1:0] REPLACE_COLOUR_RST = 24'h000000;

	// luma: (299 r + 587 g + 114 b) / 1000, numerator below 2^18
	localparam int YP_W = 18;
	localparam logic [YP_W-1:0] Y_R = 18'd299;
	localparam logic [YP_W-1:0] Y_G = 18'd587;
	localparam logic [YP_W-1:0] Y_B = 18'd114;
	localparam int Y_SHIFT   = 28;
	localparam int Y_RECIP_W = 19;
	// ceil(2^28 / 1000)
	localparam logic [Y_RECIP_W-1:0] Y_RECIP = 19'd268436;
	localparam int YM_W = YP_W + Y_RECIP_W;

	// chroma: numerators stay in 50000 .. 25550000, below 2^25
	localparam int CP_W = 24;
	localparam int CN_W = 25;
	localparam logic [CP_W-1:0] CB_R   = 24'd16874;
	localparam logic [CP_W-1:0] CB_G   = 24'd33126;
	localparam logic [CP_W-1:0] C_HALF = 24'd50000;
	localparam logic [CP_W-1:0] CR_G   = 24'd41869;
	localparam logic [CP_W-1:0] CR_B   = 24'd8131;
	localparam logic [CN_W-1:0] C_OFFSET = 25'd12800000;
	localparam int C_SHIFT   = 42;
	localparam int C_RECIP_W = 26;
	// ceil(2^42 / 100000)
	localparam logic [C_RECIP_W-1:0] C_RECIP = 26'd43980466;
	localparam int CM_W = CN_W + C_RECIP_W;

endpackage

`default_nettype wire

### hw/rtl/ryc_key.sv
`default_nettype none
`include "assert_macros.svh"

module ryc_key
	import ryc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             key_enable,
	input  wire logic [CFG_W-1:0] key_colour,
	input  wire logic [CFG_W-1:0] replacement_colour,
	input  wire ryc_pix_t         pix_in_a,
	input  wire ryc_pix_t         pix_in_b,
	output ryc_pix_t              pix_a_s1,
	output ryc_pix_t              pix_b_s1
);

	logic     hit_a;
	logic     hit_b;
	ryc_pix_t pix_a;
	ryc_pix_t pix_b;

	assign hit_a = key_enable && (pix_in_a == key_colour);
	assign hit_b = key_enable && (pix_in_b == key_colour);

	// only a lone key pixel is swapped
	always_comb begin
		pix_a = pix_in_a;
		pix_b = pix_in_b;
		if (hit_a && !hit_b) begin
			pix_a = replacement_colour;
		end else if (hit_b && !hit_a) begin
			pix_b = replacement_colour;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_a_s1 <= pix_a;
			pix_b_s1 <= pix_b;
		end
	end

	`RYC_ASSERT_NEXT(a_key_off_pass, en && !key_enable, pix_a_s1 == $past(pix_in_a) && pix_b_s1 == $past(pix_in_b), "pixels altered with key replacement off")

endmodule

`default_nettype wire

### hw/rtl/ryc_lane.sv
`default_nettype none

module ryc_lane
	import ryc_pkg::*;
(
	input  wire logic     clk,
	input  wire ryc_adv_t adv,
	input  wire ryc_pix_t pix,
	output ryc_lane_t     res
);

	logic [YP_W-1:0] yr_s2, yg_s2, yb_s2;
	logic [CP_W-1:0] cbr_s2, cbg_s2, cbb_s2;
	logic [CP_W-1:0] crr_s2, crg_s2, crb_s2;
	logic [YP_W-1:0] y_num_s3;
	logic [CN_W-1:0] cb_num_s3;
	logic [CN_W-1:0] cr_num_s3;
	logic [YM_W-1:0] y_prod_s4;
	logic [CM_W-1:0] cb_prod_s4;
	logic [CM_W-1:0] cr_prod_s4;

	// constant-weight products
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			yr_s2  <= YP_W'(pix.r) * Y_R;
			yg_s2  <= YP_W'(pix.g) * Y_G;
			yb_s2  <= YP_W'(pix.b) * Y_B;
			cbr_s2 <= CP_W'(pix.r) * CB_R;
			cbg_s2 <= CP_W'(pix.g) * CB_G;
			cbb_s2 <= CP_W'(pix.b) * C_HALF;
			crr_s2 <= CP_W'(pix.r) * C_HALF;
			crg_s2 <= CP_W'(pix.g) * CR_G;
			crb_s2 <= CP_W'(pix.b) * CR_B;
		end
	end

	// numerators are never negative, so modular arithmetic is exact
	always_ff @(posedge clk) begin
		if (adv.s3) begin
			y_num_s3  <= yr_s2 + yg_s2 + yb_s2;
			cb_num_s3 <= CN_W'(cbb_s2) + C_OFFSET - CN_W'(cbr_s2) - CN_W'(cbg_s2);
			cr_num_s3 <= CN_W'(crr_s2) + C_OFFSET - CN_W'(crg_s2) - CN_W'(crb_s2);
		end
	end

	// divide by constant through reciprocal multiply
	always_ff @(posedge clk) begin
		if (adv.s4) begin
			y_prod_s4  <= YM_W'(y_num_s3) * YM_W'(Y_RECIP);
			cb_prod_s4 <= CM_W'(cb_num_s3) * CM_W'(C_RECIP);
			cr_prod_s4 <= CM_W'(cr_num_s3) * CM_W'(C_RECIP);
		end
	end

	assign res.luma = y_prod_s4[Y_SHIFT +: 8];
	assign res.cb   = cb_prod_s4[C_SHIFT +: 8];
	assign res.cr   = cr_prod_s4[C_SHIFT +: 8];

endmodule

`default_nettype wire

### hw/rtl/ryc_merge.sv
`default_nettype none

module ryc_merge
	import ryc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      en,
	input  wire ryc_lane_t lane_a,
	input  wire ryc_lane_t lane_b,
	output ryc_out_t       out_q
);

	logic [8:0] cb_sum;
	logic [8:0] cr_sum;

	assign cb_sum = {1'b0, lane_a.cb} + {1'b0, lane_b.cb};
	assign cr_sum = {1'b0, lane_a.cr} + {1'b0, lane_b.cr};

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.first_luma  <= lane_a.luma;
			out_q.blue_chroma <= cb_sum[8:1];
			out_q.second_luma <= lane_b.luma;
			out_q.red_chroma  <= cr_sum[8:1];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/rgb_pair_to_ycbcr422.sv
// rgb_pair_to_ycbcr422: two adjacent rgb pixels in, one bt.601 4:2:2 word out
//
// input channel in_valid / in_stall / in_data carries one pixel pair per request;
// output channel out_valid / out_stall / out_data carries the two lumas and the
// averaged cb and cr. a request is taken on a clock edge with valid high and
// stall low. configuration is a plain write port (cfg_write, cfg_index,
// cfg_data): index 0 key enable, 1 key colour, 2 replacement colour; write only
// while no request is in flight.
// the accepting edge loads the key stage, and the pair then moves through the
// product, sum and reciprocal multiply stages and the chroma merge register to
// out_data.
// throughput: one pair per clock while out_stall is low, held by two conversion
// lanes each with a three-stage constant-multiply pipeline.
// when out_stall is high the output register holds; stages behind it keep
// filling bubbles, and in_stall rises only once all five stages hold data.
// reset clears every stage valid and loads the configuration defaults
// (key off, key colour ff00ff, replacement colour black).
`default_nettype none
`include "assert_macros.svh"

module rgb_pair_to_ycbcr422
	import ryc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire ryc_in_t              in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output ryc_out_t                  out_data,
	input  wire logic                 cfg_write,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	logic             key_enable_q;
	logic [CFG_W-1:0] key_colour_q;
	logic [CFG_W-1:0] replacement_colour_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4, adv_out;
	ryc_adv_t  adv;
	ryc_pix_t  pix_in_a, pix_in_b;
	ryc_pix_t  pix_a_s1, pix_b_s1;
	ryc_lane_t lane_a, lane_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_enable_q         <= 1'b0;
			key_colour_q         <= KEY_COLOUR_RST;
			replacement_colour_q <= REPLACE_COLOUR_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_KEY_ENABLE:     key_enable_q         <= cfg_data[0];
				REG_KEY_COLOUR:     key_colour_q         <= cfg_data;
				REG_REPLACE_COLOUR: replacement_colour_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage moves when it is empty or the one ahead moves
	assign adv_out = !out_valid || !out_stall;
	assign adv4    = !v_s4 || adv_out;
	assign adv3    = !v_s3 || adv4;
	assign adv2    = !v_s2 || adv3;
	assign adv1    = !v_s1 || adv2;
	assign in_stall = !adv1;

	assign adv.s2 = adv2;
	assign adv.s3 = adv3;
	assign adv.s4 = adv4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (adv1)    v_s1      <= in_valid;
			if (adv2)    v_s2      <= v_s1;
			if (adv3)    v_s3      <= v_s2;
			if (adv4)    v_s4      <= v_s3;
			if (adv_out) out_valid <= v_s4;
		end
	end

	assign pix_in_a = {in_data.first_red, in_data.first_green, in_data.first_blue};
	assign pix_in_b = {in_data.second_red, in_data.second_green, in_data.second_blue};

	ryc_key u_key (
		.clk                (clk),
		.arst_n             (arst_n),
		.en                 (adv1),
		.key_enable         (key_enable_q),
		.key_colour         (key_colour_q),
		.replacement_colour (replacement_colour_q),
		.pix_in_a           (pix_in_a),
		.pix_in_b           (pix_in_b),
		.pix_a_s1           (pix_a_s1),
		.pix_b_s1           (pix_b_s1)
	);

	ryc_lane u_lane_a (
		.clk (clk),
		.adv (adv),
		.pix (pix_a_s1),
		.res (lane_a)
	);

	ryc_lane u_lane_b (
		.clk (clk),
		.adv (adv),
		.pix (pix_b_s1),
		.res (lane_b)
	);

	ryc_merge u_merge (
		.clk    (clk),
		.en     (adv_out),
		.lane_a (lane_a),
		.lane_b (lane_b),
		.out_q  (out_data)
	);

	`RYC_ASSERT(a_stall_only_when_full, !in_stall || (v_s1 && v_s2 && v_s3 && v_s4 && out_valid && out_stall), "input stalled with a free stage")
	`RYC_ASSERT(a_out_from_s4, !$rose(out_valid) || $past(v_s4), "output valid without a request in the last stage")

endmodule

`default_nettype wire

### tb/sv/ycbcr_pair_checker.sv
`default_nettype none

module ycbcr_pair_checker
	import ryc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 in_stall,
	input  wire ryc_in_t              in_data,
	input  wire logic                 out_valid,
	input  wire logic                 out_stall,
	input  wire ryc_out_t             out_data,
	input  wire logic                 cfg_write,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output int                        fail_count,
	output int                        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic     key_on;
	ryc_pix_t key_pix;
	ryc_pix_t subst_pix;
	ryc_out_t expected_words[$];
	int       mismatches = 0;
	int       depth = 0;

	assign fail_count = mismatches;
	assign pending    = depth;

	function automatic int luma_of_pix(ryc_pix_t p);
		int r, g, b;
		r = p.r;
		g = p.g;
		b = p.b;
		return (299 * r + 587 * g + 114 * b) / 1000;
	endfunction

	function automatic int cb_of_pix(ryc_pix_t p);
		int r, g, b;
		r = p.r;
		g = p.g;
		b = p.b;
		return (-16874 * r - 33126 * g + 50000 * b + 12800000) / 100000;
	endfunction

	function automatic int cr_of_pix(ryc_pix_t p);
		int r, g, b;
		r = p.r;
		g = p.g;
		b = p.b;
		return (50000 * r - 41869 * g - 8131 * b + 12800000) / 100000;
	endfunction

	function automatic ryc_out_t predict_word(ryc_in_t d);
		ryc_pix_t a, b;
		logic     a_hit, b_hit;
		ryc_out_t w;
		a = {d.first_red, d.first_green, d.first_blue};
		b = {d.second_red, d.second_green, d.second_blue};
		// a lone key pixel is swapped, a matching pair is left alone
		if (key_on) begin
			a_hit = (a == key_pix);
			b_hit = (b == key_pix);
			if (a_hit && !b_hit)
				a = subst_pix;
			else if (!a_hit && b_hit)
				b = subst_pix;
		end
		w.first_luma  = 8'(luma_of_pix(a));
		w.second_luma = 8'(luma_of_pix(b));
		w.blue_chroma = 8'((cb_of_pix(a) + cb_of_pix(b)) / 2);
		w.red_chroma  = 8'((cr_of_pix(a) + cr_of_pix(b)) / 2);
		return w;
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s expected %0d got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_on    <= 1'b0;
			key_pix   <= KEY_COLOUR_RST;
			subst_pix <= REPLACE_COLOUR_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_KEY_ENABLE: begin
					key_on <= cfg_data[0];
				end
				REG_KEY_COLOUR: begin
					key_pix <= cfg_data;
				end
				REG_REPLACE_COLOUR: begin
					subst_pix <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always @(posedge clk) begin
		ryc_out_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$error("result %h with no request outstanding", out_data);
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					check_field("first_luma", want.first_luma, out_data.first_luma);
					check_field("blue_chroma", want.blue_chroma, out_data.blue_chroma);
					check_field("second_luma", want.second_luma, out_data.second_luma);
					check_field("red_chroma", want.red_chroma, out_data.red_chroma);
				end
			end
			if (in_valid && !in_stall)
				expected_words.push_back(predict_word(in_data));
			depth = expected_words.size();
		end
	end

endmodule

`default_nettype wire

### tb/sv/tb.sv
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ryc_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	ryc_in_t              in_data;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	ryc_out_t             out_data;
	logic                 cfg_write;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   fail_count;
	int                   pending;

	int       src_idle = 0;
	int       dst_stall = 0;
	ryc_pix_t cur_key = KEY_COLOUR_RST;

	rgb_pair_to_ycbcr422 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ycbcr_pair_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #4 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < dst_stall);
	end

	// called and returns at a falling edge
	task automatic send_pair(ryc_in_t d);
		while ($urandom_range(99) < src_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(logic on, ryc_pix_t key, ryc_pix_t subst);
		write_reg(REG_KEY_ENABLE, CFG_W'(on));
		write_reg(REG_KEY_COLOUR, key);
		write_reg(REG_REPLACE_COLOUR, subst);
		cur_key = key;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	function automatic logic [7:0] rand_component();
		int sel;
		sel = $urandom_range(7);
		if (sel == 0)
			return 8'h00;
		else if (sel == 1)
			return 8'hFF;
		return 8'($urandom());
	endfunction

	function automatic ryc_pix_t rand_pix();
		return {rand_component(), rand_component(), rand_component()};
	endfunction

	// mix of lone key pixels, key pairs and plain pairs
	function automatic ryc_in_t random_pair(ryc_pix_t key);
		ryc_pix_t a, b;
		int       mode;
		a = rand_pix();
		b = rand_pix();
		mode = $urandom_range(99);
		if (mode < 25) begin
			a = key;
		end else if (mode < 50) begin
			b = key;
		end else if (mode < 60) begin
			a = key;
			b = key;
		end
		return {a, b};
	endfunction

	task automatic run_phase(int n, int src_pct, int dst_pct);
		src_idle  = src_pct;
		dst_stall = dst_pct;
		repeat (n) send_pair(random_pair(cur_key));
		settle();
	endtask

	initial begin
		int       src, dst;
		ryc_pix_t key, subst;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_write = 1'b0;
		cfg_index = REG_KEY_ENABLE;
		cfg_data  = '0;
		arst_n    = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings, key off: extremes and key pixels passing unchanged
		send_pair({24'h000000, 24'h000000});
		send_pair({24'hFFFFFF, 24'hFFFFFF});
		send_pair({24'hFFFFFF, 24'h000000});
		send_pair({24'h000000, 24'hFFFFFF});
		send_pair({24'hFF0000, 24'h00FF00});
		send_pair({24'h0000FF, 24'hFFFF00});
		send_pair({24'hFF00FF, 24'h123456});
		send_pair({24'hFF00FF, 24'hFF00FF});
		send_pair({24'h00FFFF, 24'hFF00FF});
		settle();

		configure(1'b1, 24'hFF00FF, 24'h000000);
		send_pair({24'hFF00FF, 24'h808080});
		send_pair({24'h808080, 24'hFF00FF});
		send_pair({24'hFF00FF, 24'hFF00FF});
		send_pair({24'h010203, 24'h040506});
		settle();

		configure(1'b1, 24'h000000, 24'hFFFFFF);
		send_pair({24'h000000, 24'hFFFFFF});
		send_pair({24'hFFFFFF, 24'h000000});
		send_pair({24'h000000, 24'h000000});
		send_pair({24'hFFFFFF, 24'hFFFFFF});
		settle();

		configure(1'b1, 24'hFFFFFF, 24'h000000);
		send_pair({24'hFFFFFF, 24'h0000FF});
		send_pair({24'h00FF00, 24'hFFFFFF});
		send_pair({24'hFFFFFF, 24'hFFFFFF});
		settle();

		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin
					src = 0;
					dst = 0;
				end
				1: begin
					src = 50;
					dst = 0;
				end
				2: begin
					src = 0;
					dst = 50;
				end
				default: begin
					src = 34;
					dst = 34;
				end
			endcase
			key   = 24'($urandom());
			subst = 24'($urandom());
			if (p == 2) begin
				key   = 24'h000000;
				subst = 24'hFFFFFF;
			end else if (p == 5) begin
				key   = 24'hFFFFFF;
				subst = 24'h000000;
			end
			configure(p != 0 && p != 4, key, subst);
			run_phase(160, src, dst);
		end

		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
+incdir+hw/rtl
hw/rtl/ryc_pkg.sv
hw/rtl/ryc_key.sv
hw/rtl/ryc_lane.sv
hw/rtl/ryc_merge.sv
hw/rtl/rgb_pair_to_ycbcr422.sv
tb/sv/ycbcr_pair_checker.sv
tb/sv/tb.sv
